/* sv/tgr_pkg.sv */
package tgr_pkg;

	localparam int COORD_BITS = 12;
	localparam int TIME_BITS  = 32;
	localparam int FINGER_W   = 4;

	localparam int SD_W      = 12;
	localparam int FT_W      = 16;
	localparam int PT_W      = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SWIPE_DISTANCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLICK_TIME      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PINCH_THRESHOLD = 2'd2;

	localparam logic [SD_W-1:0] SD_RESET = 12'd80;
	localparam logic [FT_W-1:0] FT_RESET = 16'd200;
	localparam logic [PT_W-1:0] PT_RESET = 10'd8;

	localparam int D2_W       = 2 * COORD_BITS + 1;
	localparam int ROOT_W     = (D2_W + 8 + 1) / 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SQRT_CNT_W = $clog2(ROOT_W);
	localparam int SPAN_W     = 17;
	localparam logic [SPAN_W-1:0] SPAN_MAX = 17'h1FFFF;
	localparam int SPAN_CMP_W = (ROOT_W > SPAN_W) ? ROOT_W : SPAN_W;
	localparam int MUL_W      = (COORD_BITS > SD_W) ? COORD_BITS : SD_W;
	localparam int REL_W      = (D2_W > 2 * SD_W) ? D2_W : 2 * SD_W;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_LIFT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MULTI  = 2'd2;

	typedef struct packed {
		logic [SD_W-1:0] swipe_distance;
		logic [FT_W-1:0] flick_time_ms;
		logic [PT_W-1:0] pinch_threshold;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [FINGER_W-1:0]   fingers;
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic [TIME_BITS-1:0]  now;
		logic [COORD_BITS-1:0] pdx;
		logic [COORD_BITS-1:0] pdy;
	} item_t;

	typedef struct packed {
		logic                  tap;
		logic                  swipe;
		logic                  flick;
		logic                  pinch_in;
		logic                  pinch_out;
		logic                  touching;
		logic [FINGER_W-1:0]   fingers_seen;
		logic [COORD_BITS-1:0] begin_x;
		logic [COORD_BITS-1:0] begin_y;
		logic [COORD_BITS-1:0] latest_x;
		logic [COORD_BITS-1:0] latest_y;
	} result_t;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

/* sv/tgr_front.sv */
module tgr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [tgr_pkg::FINGER_W-1:0]   finger_count,
	input  logic [tgr_pkg::COORD_BITS-1:0] first_x,
	input  logic [tgr_pkg::COORD_BITS-1:0] first_y,
	input  logic [tgr_pkg::COORD_BITS-1:0] second_x,
	input  logic [tgr_pkg::COORD_BITS-1:0] second_y,
	input  logic [tgr_pkg::TIME_BITS-1:0]  now_ms,
	input  logic                           q_pop,
	output logic                           q_empty,
	output tgr_pkg::item_t                 q_head
);
	import tgr_pkg::*;

	item_t             q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	item_t             item_in;
	logic              push_ok;
	logic              pop_ok;

	always_comb begin
		item_in.fingers = finger_count;
		item_in.ax      = first_x;
		item_in.ay      = first_y;
		item_in.now     = now_ms;
		item_in.pdx     = abs_diff(first_x, second_x);
		item_in.pdy     = abs_diff(first_y, second_y);
		if (finger_count == '0) begin
			item_in.kind = KIND_LIFT;
		end else if (finger_count == FINGER_W'(1)) begin
			item_in.kind = KIND_SINGLE;
		end else begin
			item_in.kind = KIND_MULTI;
		end
	end

	assign full    = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign q_head  = q_mem_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok  = q_pop && !q_empty;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/tgr_isqrt.sv */
module tgr_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tgr_pkg::RAD_W-1:0]  radicand,
	output logic                       done,
	output logic [tgr_pkg::ROOT_W-1:0] root
);
	import tgr_pkg::*;

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W+1:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic [ROOT_W+3:0]     rem_sh;
	logic [ROOT_W+3:0]     trial;
	logic                  last_step;

	assign rem_sh    = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial     = rem_sh - {2'b00, root_q, 2'b01};
	assign last_step = (cnt_q == SQRT_CNT_W'(ROOT_W - 1));
	assign done      = busy_q && last_step;
	assign root      = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= trial[ROOT_W+3] ? rem_sh[ROOT_W+1:0] : trial[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ~trial[ROOT_W+3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/tgr_back.sv */
module tgr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tgr_pkg::cfg_t    cfg,
	input  logic             q_empty,
	input  tgr_pkg::item_t   q_head,
	output logic             q_pop,
	output tgr_pkg::result_t res,
	output logic             res_valid,
	input  logic             pop
);
	import tgr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_SQT  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]            state_q;
	item_t                 cur_q;
	logic [COORD_BITS-1:0] dx_q;
	logic [COORD_BITS-1:0] dy_q;
	logic [D2_W-1:0]       acc_q;
	logic [2*SD_W-1:0]     thr_q;
	result_t               res_q;
	logic                  res_valid_q;

	logic                  active_q;
	logic [COORD_BITS-1:0] org_x_q;
	logic [COORD_BITS-1:0] org_y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [TIME_BITS-1:0]  begin_ms_q;
	logic [SPAN_W-1:0]     span_q;

	logic [MUL_W-1:0]      mul_a;
	logic [2*MUL_W-1:0]    prod;
	logic [D2_W-1:0]       sum_c;
	logic                  head_release;
	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [ROOT_W-1:0]     sqrt_root;
	logic [SPAN_CMP_W-1:0] root_ext;
	logic [SPAN_W-1:0]     span_c;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  fire;

	result_t               res_c;
	logic                  active_d;
	logic [COORD_BITS-1:0] org_x_d;
	logic [COORD_BITS-1:0] org_y_d;
	logic [COORD_BITS-1:0] last_x_d;
	logic [COORD_BITS-1:0] last_y_d;
	logic [TIME_BITS-1:0]  begin_ms_d;
	logic [SPAN_W-1:0]     span_d;

	assign q_pop        = (state_q == ST_IDLE) && !q_empty;
	assign head_release = (q_head.kind == KIND_LIFT) && active_q;
	assign res          = res_q;
	assign res_valid    = res_valid_q;
	assign fire         = (state_q == ST_DONE) && (!res_valid_q || pop);

	always_comb begin
		if (state_q == ST_SQT) begin
			mul_a = MUL_W'(cfg.swipe_distance);
		end else if (state_q == ST_SQY) begin
			mul_a = MUL_W'(dy_q);
		end else begin
			mul_a = MUL_W'(dx_q);
		end
	end

	assign prod       = mul_a * mul_a;
	assign sum_c      = acc_q + D2_W'(prod);
	assign sqrt_start = (state_q == ST_SQY) && (cur_q.kind != KIND_LIFT);

	tgr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (RAD_W'({sum_c, 8'h00})),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign root_ext = SPAN_CMP_W'(sqrt_root);
	assign span_c   = (root_ext > SPAN_CMP_W'(SPAN_MAX)) ? SPAN_MAX : SPAN_W'(root_ext);
	assign elapsed  = cur_q.now - begin_ms_q;

	always_comb begin
		active_d   = active_q;
		org_x_d    = org_x_q;
		org_y_d    = org_y_q;
		last_x_d   = last_x_q;
		last_y_d   = last_y_q;
		begin_ms_d = begin_ms_q;
		span_d     = span_q;
		res_c      = '0;
		if (cur_q.kind == KIND_LIFT) begin
			if (active_q) begin
				res_c.tap   = REL_W'(acc_q) < REL_W'(thr_q);
				res_c.swipe = !res_c.tap;
				res_c.flick = res_c.swipe && (elapsed <= TIME_BITS'(cfg.flick_time_ms));
				active_d    = 1'b0;
				span_d      = '0;
			end
		end else begin
			if (!active_q) begin
				active_d   = 1'b1;
				org_x_d    = cur_q.ax;
				org_y_d    = cur_q.ay;
				begin_ms_d = cur_q.now;
			end
			last_x_d = cur_q.ax;
			last_y_d = cur_q.ay;
			if (cur_q.kind == KIND_MULTI) begin
				if (span_q != '0) begin
					res_c.pinch_out = (span_c > span_q) &&
						((span_c - span_q) > SPAN_W'(cfg.pinch_threshold));
					res_c.pinch_in  = (span_c <= span_q) &&
						((span_q - span_c) > SPAN_W'(cfg.pinch_threshold));
				end
				span_d = span_c;
			end
		end
		res_c.touching     = active_d;
		res_c.fingers_seen = cur_q.fingers;
		res_c.begin_x      = org_x_d;
		res_c.begin_y      = org_y_d;
		res_c.latest_x     = last_x_d;
		res_c.latest_y     = last_y_d;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
			if (head_release) begin
				dx_q <= abs_diff(last_x_q, org_x_q);
				dy_q <= abs_diff(last_y_q, org_y_q);
			end else begin
				dx_q <= q_head.pdx;
				dy_q <= q_head.pdy;
			end
		end
		if (state_q == ST_SQX) begin
			acc_q <= D2_W'(prod);
		end else if (state_q == ST_SQY) begin
			acc_q <= sum_c;
		end
		if (state_q == ST_SQT) begin
			thr_q <= (2 * SD_W)'(prod);
		end
		if (fire) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			active_q    <= 1'b0;
			org_x_q     <= '0;
			org_y_q     <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			begin_ms_q  <= '0;
			span_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (head_release || (q_head.kind == KIND_MULTI)) begin
							state_q <= ST_SQX;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= (cur_q.kind == KIND_LIFT) ? ST_SQT : ST_ROOT;
				end
				ST_SQT: begin
					state_q <= ST_DONE;
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				res_valid_q <= 1'b1;
				active_q    <= active_d;
				org_x_q     <= org_x_d;
				org_y_q     <= org_y_d;
				last_x_q    <= last_x_d;
				last_y_q    <= last_y_d;
				begin_ms_q  <= begin_ms_d;
				span_q      <= span_d;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/touch_gesture_recognizer.sv */
// Touch gesture recognizer: each pushed item is one touch-panel frame and yields exactly one
// result item with the tap, swipe, flick and pinch flags plus the current touch position.
// A two-entry input queue classifies frames by finger count and takes new items while the
// back end works. With the back end free, a frame with no release and fewer than two fingers
// goes straight from the queue to the result register, a release first squares the travelled
// distance and the swipe distance, and a frame with two or more fingers squares the finger
// spread and waits for the square-root unit that yields one bit of the Q13.4 span per cycle.
// The back end takes no new item until it has finished the last one. One shared multiplier
// forms the squared distances over successive cycles. A finished result waits in an output
// register until popped, and the back end holds its next result until that register is free.
// Configuration writes take effect at the next clock edge.
module touch_gesture_recognizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [tgr_pkg::FINGER_W-1:0]   finger_count,
	input  logic [tgr_pkg::COORD_BITS-1:0] first_x,
	input  logic [tgr_pkg::COORD_BITS-1:0] first_y,
	input  logic [tgr_pkg::COORD_BITS-1:0] second_x,
	input  logic [tgr_pkg::COORD_BITS-1:0] second_y,
	input  logic [tgr_pkg::TIME_BITS-1:0]  now_ms,
	input  logic                           cfg_we,
	input  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_W-1:0]      cfg_data,
	output logic                           empty,
	input  logic                           pop,
	output logic                           tap,
	output logic                           swipe,
	output logic                           flick,
	output logic                           pinch_in,
	output logic                           pinch_out,
	output logic                           touching,
	output logic [tgr_pkg::FINGER_W-1:0]   fingers_seen,
	output logic [tgr_pkg::COORD_BITS-1:0] begin_x,
	output logic [tgr_pkg::COORD_BITS-1:0] begin_y,
	output logic [tgr_pkg::COORD_BITS-1:0] latest_x,
	output logic [tgr_pkg::COORD_BITS-1:0] latest_y
);
	import tgr_pkg::*;

	cfg_t    cfg_q;
	logic    q_pop;
	logic    q_empty;
	item_t   q_head;
	result_t res;
	logic    res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swipe_distance  <= SD_RESET;
			cfg_q.flick_time_ms   <= FT_RESET;
			cfg_q.pinch_threshold <= PT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SWIPE_DISTANCE: begin
					cfg_q.swipe_distance <= cfg_data[SD_W-1:0];
				end
				REG_FLICK_TIME: begin
					cfg_q.flick_time_ms <= cfg_data[FT_W-1:0];
				end
				REG_PINCH_THRESHOLD: begin
					cfg_q.pinch_threshold <= cfg_data[PT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tgr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.finger_count (finger_count),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.now_ms       (now_ms),
		.q_pop        (q_pop),
		.q_empty      (q_empty),
		.q_head       (q_head)
	);

	tgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res       (res),
		.res_valid (res_valid),
		.pop       (pop)
	);

	assign empty        = !res_valid;
	assign tap          = res.tap;
	assign swipe        = res.swipe;
	assign flick        = res.flick;
	assign pinch_in     = res.pinch_in;
	assign pinch_out    = res.pinch_out;
	assign touching     = res.touching;
	assign fingers_seen = res.fingers_seen;
	assign begin_x      = res.begin_x;
	assign begin_y      = res.begin_y;
	assign latest_x     = res.latest_x;
	assign latest_y     = res.latest_y;

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end took an item from an empty queue");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("pending result was lost");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!(tap && swipe) && (!flick || swipe) && !(pinch_in && pinch_out)))
		else $error("inconsistent gesture flags");

	a_release_ends_touch: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (tap || swipe)) |-> (!touching && (fingers_seen == '0)))
		else $error("release reported while a touch is active");
`endif

endmodule
